// ===== rtl/brl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants for the Bresenham line pixel generator.
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int COORD_BITS = 11;
    localparam int CLIP_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 1;
    localparam int CNT_BITS   = COORD_BITS + 1;
    localparam int COLOR_BITS = 8;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RESET  = CLIP_BITS'(1920);
    localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RESET = CLIP_BITS'(1080);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_HEIGHT = 1'b1;

    // step direction codes, two's complement
    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_POS  = 2'b01;
    localparam logic [1:0] STEP_NEG  = 2'b11;

    typedef enum logic [0:0] {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

    typedef struct packed {
        action_t                action;
        logic [COORD_BITS-1:0]  x_start;
        logic [COORD_BITS-1:0]  y_start;
        logic [COORD_BITS-1:0]  x_end;
        logic [COORD_BITS-1:0]  y_end;
        logic [COLOR_BITS-1:0]  red;
        logic [COLOR_BITS-1:0]  green;
        logic [COLOR_BITS-1:0]  blue;
    } s_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  pixel_x;
        logic [COORD_BITS-1:0]  pixel_y;
        logic [COLOR_BITS-1:0]  red_out;
        logic [COLOR_BITS-1:0]  green_out;
        logic [COLOR_BITS-1:0]  blue_out;
        logic                   visible;
        logic                   last;
    } m_item_t;

    typedef struct packed {
        logic [CLIP_BITS-1:0]   clip_width;
        logic [CLIP_BITS-1:0]   clip_height;
    } clip_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/brl_line_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brl_line_core
// Line state registers: set up a line on a start transaction and emit one
// pixel per step transaction in a line, advancing the error accumulator.
// ----------------------------------------------------------------------------
module brl_line_core
    import brl_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      item_valid,
    input  wire s_item_t   item,
    input  wire clip_cfg_t clip,
    output logic           result_valid,
    output m_item_t        result,
    output logic           line_busy
);

    logic [COORD_BITS-1:0]   cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg, cur_y_next;
    logic [ERR_BITS-1:0]     err_reg, err_next;
    logic [COORD_BITS-1:0]   major_reg, major_next;
    logic [COORD_BITS-1:0]   minor_reg, minor_next;
    logic [1:0]              diag_x_reg, diag_x_next;
    logic [1:0]              diag_y_reg, diag_y_next;
    logic [1:0]              str_x_reg, str_x_next;
    logic [1:0]              str_y_reg, str_y_next;
    logic [CNT_BITS-1:0]     left_reg, left_next;
    logic [3*COLOR_BITS-1:0] color_reg, color_next;
    logic                    busy_reg, busy_next;

    logic [COORD_BITS-1:0]   adx, ady;
    logic [1:0]              sx, sy;
    logic                    x_major;
    logic [ERR_BITS-1:0]     err_sum;
    logic                    take_diag;
    logic                    do_start, do_step;

    function automatic logic [COORD_BITS-1:0] apply_step(
        input logic [COORD_BITS-1:0] coord,
        input logic [1:0]            code
    );
        if (code[1]) begin
            return coord - COORD_BITS'(1);
        end
        return coord + COORD_BITS'(code[0]);
    endfunction

    assign do_start = item_valid && (item.action == ACT_START);
    assign do_step  = item_valid && (item.action == ACT_STEP) && busy_reg;

    // line setup
    always_comb begin
        adx = (item.x_end > item.x_start) ? item.x_end - item.x_start
                                          : item.x_start - item.x_end;
        ady = (item.y_end > item.y_start) ? item.y_end - item.y_start
                                          : item.y_start - item.y_end;
        priority if (item.x_end > item.x_start) begin
            sx = STEP_POS;
        end else if (item.x_end < item.x_start) begin
            sx = STEP_NEG;
        end else begin
            sx = STEP_ZERO;
        end
        priority if (item.y_end > item.y_start) begin
            sy = STEP_POS;
        end else if (item.y_end < item.y_start) begin
            sy = STEP_NEG;
        end else begin
            sy = STEP_ZERO;
        end
        // ties go to y-major
        x_major = adx > ady;
    end

    // accumulator step
    assign err_sum   = err_reg + {1'b0, minor_reg};
    assign take_diag = err_sum >= {1'b0, major_reg};

    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_next    = err_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        diag_x_next = diag_x_reg;
        diag_y_next = diag_y_reg;
        str_x_next  = str_x_reg;
        str_y_next  = str_y_reg;
        left_next   = left_reg;
        color_next  = color_reg;
        busy_next   = busy_reg;
        if (do_start) begin
            diag_x_next = sx;
            diag_y_next = sy;
            major_next  = x_major ? adx : ady;
            minor_next  = x_major ? ady : adx;
            str_x_next  = x_major ? sx : STEP_ZERO;
            str_y_next  = x_major ? STEP_ZERO : sy;
            cur_x_next  = item.x_start;
            cur_y_next  = item.y_start;
            err_next    = {1'b0, major_next} >> 1;
            left_next   = {1'b0, major_next} + CNT_BITS'(1);
            color_next  = {item.red, item.green, item.blue};
            busy_next   = 1'b1;
        end else if (do_step) begin
            if (take_diag) begin
                err_next   = err_sum - {1'b0, major_reg};
                cur_x_next = apply_step(cur_x_reg, diag_x_reg);
                cur_y_next = apply_step(cur_y_reg, diag_y_reg);
            end else begin
                err_next   = err_sum;
                cur_x_next = apply_step(cur_x_reg, str_x_reg);
                cur_y_next = apply_step(cur_y_reg, str_y_reg);
            end
            left_next = left_reg - CNT_BITS'(1);
            busy_next = left_reg != CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            err_reg    <= '0;
            major_reg  <= '0;
            minor_reg  <= '0;
            diag_x_reg <= STEP_ZERO;
            diag_y_reg <= STEP_ZERO;
            str_x_reg  <= STEP_ZERO;
            str_y_reg  <= STEP_ZERO;
            left_reg   <= '0;
            color_reg  <= '0;
            busy_reg   <= 1'b0;
        end else begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            err_reg    <= err_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            diag_x_reg <= diag_x_next;
            diag_y_reg <= diag_y_next;
            str_x_reg  <= str_x_next;
            str_y_reg  <= str_y_next;
            left_reg   <= left_next;
            color_reg  <= color_next;
            busy_reg   <= busy_next;
        end
    end

    always_comb begin
        result_valid     = do_step;
        result.pixel_x   = cur_x_reg;
        result.pixel_y   = cur_y_reg;
        result.red_out   = color_reg[3*COLOR_BITS-1:2*COLOR_BITS];
        result.green_out = color_reg[2*COLOR_BITS-1:COLOR_BITS];
        result.blue_out  = color_reg[COLOR_BITS-1:0];
        result.visible   = ({1'b0, cur_x_reg} < clip.clip_width) &&
                           ({1'b0, cur_y_reg} < clip.clip_height);
        result.last      = left_reg == CNT_BITS'(1);
    end

    assign line_busy = busy_reg;

endmodule

`default_nettype wire

// ===== rtl/brl_out_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brl_out_skid
// Result register with a skid stage, so a pixel can be taken in while the
// previous one waits on the output.
// ----------------------------------------------------------------------------
module brl_out_skid
    import brl_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire m_item_t push_data,
    output logic         room,
    output logic         m_valid,
    input  wire logic    m_ready,
    output m_item_t      m_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    m_item_t out_data_reg, out_data_next;
    m_item_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // drain the skid stage into the output
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign room    = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/bresenham_line_pixel_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A step transaction's pixel is registered in the result buffer (output register,
// or skid stage while the output stalls) before it appears on m_valid; a start
// transaction gives no pixel and sets up the line. Throughput: one transaction per
// cycle while the buffer has room; a two-entry result buffer absorbs one stall.
// Reset (aresetn low, synchronous): no line active, result buffer empty,
// clip width 1920 and clip height 1080.
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator
// All-octant Bresenham line generator, one pixel per step transaction in a line.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator
    import brl_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire s_item_t                 s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output m_item_t                      m_data,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CLIP_BITS-1:0]    cfg_data
);

    clip_cfg_t clip_reg, clip_next;
    logic      accept;
    logic      core_valid;
    m_item_t   core_result;
    logic      line_busy;
    logic      room;

    always_comb begin
        clip_next = clip_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_CLIP_WIDTH:  clip_next.clip_width  = cfg_data;
                CFG_CLIP_HEIGHT: clip_next.clip_height = cfg_data;
                default:         clip_next = clip_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg.clip_width  <= CLIP_WIDTH_RESET;
            clip_reg.clip_height <= CLIP_HEIGHT_RESET;
        end else begin
            clip_reg <= clip_next;
        end
    end

    assign s_ready = room;
    assign accept  = s_valid && s_ready;

    brl_line_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (accept),
        .item         (s_data),
        .clip         (clip_reg),
        .result_valid (core_valid),
        .result       (core_result),
        .line_busy    (line_busy)
    );

    brl_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (core_valid),
        .push_data (core_result),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a full skid stage means the output register is holding too
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("skid stage full with output register empty");

    // the final pixel closes the line
    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (core_valid && core_result.last) |=> !line_busy)
        else $error("line still active after last pixel");

    // a start transaction opens a line
    a_start_opens_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.action == ACT_START) |=> line_busy)
        else $error("line not active after start");

    // a pixel is produced only from a step transaction
    a_pixel_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        core_valid |-> (accept && s_data.action == ACT_STEP))
        else $error("pixel produced without a step transaction");

endmodule

`default_nettype wire
